### sv/rcal_pkg.sv
// Package for the range count block: field widths, reset values, input codes
// and the write-enable struct shared by the controller and the element store.
// No dependencies.
`default_nettype none

package rcal_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int BLOCK_SIZE_DEF   = 32;

   localparam int LENGTH_W = 11;
   localparam int POS_W    = 10;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 11;

   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 11'd1024;
   localparam logic [COUNT_W-1:0]  COUNT_SAT    = 11'd2047;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic elem;
      logic sorted;
   } store_we_type;

endpackage

`default_nettype wire

### sv/rcal_if.sv
// Valid/ready channel interfaces for requests, responses and the length register.
// Depends on rcal_pkg.
`default_nettype none

interface rcal_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 mode;
   logic        [rcal_pkg::POS_W-1:0]    position;
   logic signed [rcal_pkg::VALUE_W-1:0]  operand;
   logic signed [rcal_pkg::VALUE_W-1:0]  threshold;
   modport source (output valid, mode, position, operand, threshold, input ready);
   modport sink (input valid, mode, position, operand, threshold, output ready);
endinterface

interface rcal_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rcal_pkg::COUNT_W-1:0]   count;
   modport source (output valid, count, input ready);
   modport sink (input valid, count, output ready);
endinterface

interface rcal_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rcal_pkg::LENGTH_W-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### sv/rcal_store.sv
// Element array and per-block sorted copy, sharing one write and one read address.
// Read data is registered. Depends on rcal_pkg.
`default_nettype none

module rcal_store #(
   parameter int DEPTH = rcal_pkg::MAX_ELEMENTS_DEF,
   parameter int AW    = $clog2(rcal_pkg::MAX_ELEMENTS_DEF)
) (
   input  wire logic                           clock,
   input  wire rcal_pkg::store_we_type         we,
   input  wire logic [AW-1:0]                  waddr,
   input  wire logic [rcal_pkg::VALUE_W-1:0]   wdata,
   input  wire logic [AW-1:0]                  raddr,
   output      logic [rcal_pkg::VALUE_W-1:0]   elem_rdata,
   output      logic [rcal_pkg::VALUE_W-1:0]   sort_rdata
);
   import rcal_pkg::*;

   logic [VALUE_W-1:0] elem_mem [DEPTH];
   logic [VALUE_W-1:0] sort_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we.elem) begin
         elem_mem[waddr] <= wdata;
      end
      if (we.sorted) begin
         sort_mem[waddr] <= wdata;
      end
      elem_rdata <= elem_mem[raddr];
      sort_rdata <= sort_mem[raddr];
   end

endmodule

`default_nettype wire

### sv/range_count_at_least_with_updates.sv
// Range count at or above a threshold with point writes, over blocks kept sorted.
// A write transaction (mode 0) replaces one element and moves the new value to its
// sorted place in its block; a query (mode 1) returns the count of elements in
// position..operand that are at least threshold. After reset the block clears both
// memories before it accepts requests. One request is handled at a time by a
// sequencer around a single memory read port.
// Depends on rcal_pkg, rcal_if and rcal_store.
`default_nettype none

module range_count_at_least_with_updates #(
   parameter int MAX_ELEMENTS = rcal_pkg::MAX_ELEMENTS_DEF,
   parameter int BLOCK_SIZE   = rcal_pkg::BLOCK_SIZE_DEF
) (
   input wire logic     clock,
   input wire logic     reset,
   rcal_req_if.sink     req,
   rcal_rsp_if.source   rsp,
   rcal_csr_if.sink     csr
);
   import rcal_pkg::*;

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int IW = (AW + 1 > LENGTH_W) ? AW + 1 : LENGTH_W;
   localparam logic [IW-1:0] MAX_I  = IW'(MAX_ELEMENTS);
   localparam logic [IW-1:0] BLK_I  = IW'(BLOCK_SIZE);
   localparam logic [AW-1:0] CLR_LAST = AW'(MAX_ELEMENTS - 1);

   typedef enum logic [13:0] {
      S_CLEAR    = 14'b00000000000001,
      S_IDLE     = 14'b00000000000010,
      S_W_RD     = 14'b00000000000100,
      S_W_OLD    = 14'b00000000001000,
      S_BS_ISSUE = 14'b00000000010000,
      S_BS_CMP   = 14'b00000000100000,
      S_UP_RD    = 14'b00000001000000,
      S_UP_CMP   = 14'b00000010000000,
      S_DN_RD    = 14'b00000100000000,
      S_DN_CMP   = 14'b00001000000000,
      S_W_FIN    = 14'b00010000000000,
      S_Q_SET    = 14'b00100000000000,
      S_Q_STEP   = 14'b01000000000000,
      S_Q_ELEM   = 14'b10000000000000
   } state_type;

   state_type             state_ff, state_in;
   logic                  resp_ff, resp_in;
   logic                  query_ff, query_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [LENGTH_W-1:0]   length_ff, length_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [IW-1:0]         lo_ff, lo_in;
   logic [IW-1:0]         hi_ff, hi_in;
   logic [IW-1:0]         mid_ff, mid_in;
   logic [IW-1:0]         lim_lo_ff, lim_lo_in;
   logic [IW-1:0]         lim_hi_ff, lim_hi_in;
   logic [IW-1:0]         cnt_ff, cnt_in;
   logic [VALUE_W-1:0]    val_ff, val_in;
   logic [VALUE_W-1:0]    key_ff, key_in;

   store_we_type          we;
   logic [AW-1:0]         waddr;
   logic [VALUE_W-1:0]    wdata;
   logic [AW-1:0]         raddr;
   logic [VALUE_W-1:0]    elem_rd;
   logic [VALUE_W-1:0]    sort_rd;

   logic [IW-1:0]         eff_len;
   logic [IW-1:0]         right;
   logic [IW-1:0]         blk_start;
   logic [IW-1:0]         blk_end;

   rcal_store #(
      .DEPTH (MAX_ELEMENTS),
      .AW    (AW)
   ) u_store (
      .clock      (clock),
      .we         (we),
      .waddr      (waddr),
      .wdata      (wdata),
      .raddr      (raddr),
      .elem_rdata (elem_rd),
      .sort_rdata (sort_rd)
   );

   assign eff_len   = (IW'(length_ff) > MAX_I) ? MAX_I : IW'(length_ff);
   assign right     = (val_ff[VALUE_W-2:0] > (VALUE_W-1)'(eff_len - 1'b1)) ?
                      (eff_len - 1'b1) : IW'(val_ff[VALUE_W-2:0]);
   assign blk_start = IW'((idx_ff / BLOCK_SIZE) * BLOCK_SIZE);
   assign blk_end   = (blk_start + BLK_I > MAX_I) ? MAX_I : (blk_start + BLK_I);

   assign req.ready = (state_ff == S_IDLE) && !resp_ff;
   assign rsp.valid = resp_ff;
   assign rsp.count = (cnt_ff > IW'(COUNT_SAT)) ? COUNT_SAT : cnt_ff[COUNT_W-1:0];
   assign csr.ready = 1'b1;

   always_comb begin
      state_in  = state_ff;
      resp_in   = resp_ff;
      query_in  = query_ff;
      clr_in    = clr_ff;
      length_in = length_ff;
      idx_in    = idx_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      lim_lo_in = lim_lo_ff;
      lim_hi_in = lim_hi_ff;
      cnt_in    = cnt_ff;
      val_in    = val_ff;
      key_in    = key_ff;
      we        = '0;
      waddr     = idx_ff[AW-1:0];
      wdata     = val_ff;
      raddr     = idx_ff[AW-1:0];

      if (csr.valid) begin
         length_in = csr.data;
      end
      if (resp_ff && rsp.ready) begin
         resp_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            we     = '{elem: 1'b1, sorted: 1'b1};
            waddr  = clr_ff;
            wdata  = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid && req.ready) begin
               idx_in   = IW'(req.position);
               val_in   = req.operand;
               key_in   = req.threshold;
               query_in = (req.mode == MODE_QUERY);
               if (req.mode == MODE_QUERY) begin
                  state_in = S_Q_SET;
               end else if (IW'(req.position) < eff_len) begin
                  state_in = S_W_RD;
               end
            end
         end
         S_W_RD: begin
            state_in = S_W_OLD;
         end
         S_W_OLD: begin
            if (elem_rd == val_ff) begin
               state_in = S_IDLE;
            end else begin
               we.elem   = 1'b1;
               key_in    = elem_rd;
               lo_in     = blk_start;
               lim_lo_in = blk_start;
               hi_in     = blk_end;
               lim_hi_in = blk_end;
               state_in  = S_BS_ISSUE;
            end
         end
         S_BS_ISSUE: begin
            if (lo_ff < hi_ff) begin
               mid_in   = lo_ff + ((hi_ff - lo_ff) >> 1);
               raddr    = mid_in[AW-1:0];
               state_in = S_BS_CMP;
            end else if (query_ff) begin
               cnt_in   = cnt_ff + (idx_ff + BLK_I - lo_ff);
               idx_in   = idx_ff + BLK_I;
               state_in = S_Q_STEP;
            end else begin
               idx_in   = lo_ff;
               state_in = S_UP_RD;
            end
         end
         S_BS_CMP: begin
            if ($signed(sort_rd) < $signed(key_ff)) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_BS_ISSUE;
         end
         S_UP_RD: begin
            raddr = AW'(idx_ff + 1'b1);
            if (idx_ff + 1'b1 < lim_hi_ff) begin
               state_in = S_UP_CMP;
            end else begin
               state_in = S_DN_RD;
            end
         end
         S_UP_CMP: begin
            if ($signed(sort_rd) < $signed(val_ff)) begin
               we.sorted = 1'b1;
               wdata     = sort_rd;
               idx_in    = idx_ff + 1'b1;
               state_in  = S_UP_RD;
            end else begin
               state_in  = S_DN_RD;
            end
         end
         S_DN_RD: begin
            raddr = AW'(idx_ff - 1'b1);
            if (idx_ff > lim_lo_ff) begin
               state_in = S_DN_CMP;
            end else begin
               state_in = S_W_FIN;
            end
         end
         S_DN_CMP: begin
            if ($signed(val_ff) < $signed(sort_rd)) begin
               we.sorted = 1'b1;
               wdata     = sort_rd;
               idx_in    = idx_ff - 1'b1;
               state_in  = S_DN_RD;
            end else begin
               state_in  = S_W_FIN;
            end
         end
         S_W_FIN: begin
            we.sorted = 1'b1;
            state_in  = S_IDLE;
         end
         S_Q_SET: begin
            cnt_in    = '0;
            lim_hi_in = right;
            if (eff_len == '0 || val_ff[VALUE_W-1] || idx_ff > right) begin
               resp_in  = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_Q_STEP;
            end
         end
         S_Q_STEP: begin
            if (idx_ff > lim_hi_ff) begin
               resp_in  = 1'b1;
               state_in = S_IDLE;
            end else if ((idx_ff % BLOCK_SIZE) == 0 &&
                         idx_ff + BLK_I - 1'b1 <= lim_hi_ff) begin
               lo_in    = idx_ff;
               hi_in    = idx_ff + BLK_I;
               state_in = S_BS_ISSUE;
            end else begin
               state_in = S_Q_ELEM;
            end
         end
         S_Q_ELEM: begin
            if ($signed(elem_rd) >= $signed(key_ff)) begin
               cnt_in = cnt_ff + 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_Q_STEP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         resp_ff   <= 1'b0;
         clr_ff    <= '0;
         length_ff <= LENGTH_RESET;
      end else begin
         state_ff  <= state_in;
         resp_ff   <= resp_in;
         clr_ff    <= clr_in;
         length_ff <= length_in;
      end
      query_ff  <= query_in;
      idx_ff    <= idx_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      lim_lo_ff <= lim_lo_in;
      lim_hi_ff <= lim_hi_in;
      cnt_ff    <= cnt_in;
      val_ff    <= val_in;
      key_ff    <= key_in;
   end

endmodule

`default_nettype wire

### tb/sv/tb_rcal_if.sv
// Testbench note: the channel interfaces are taken from the RTL file rcal_if.sv;
// this file only holds a small helper package of testbench types. Depends on rcal_pkg.
`timescale 1ns / 100ps
`default_nettype none

package tb_rcal_pkg;
   import rcal_pkg::*;

   typedef struct packed {
      logic                      mode;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] operand;
      logic signed [VALUE_W-1:0] threshold;
   } request_type;
endpackage

`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for range_count_at_least_with_updates: random writes and range-count
// queries with a built-in predictor, idling phases and back-pressure. Depends on
// rcal_pkg, rcal_if, tb_rcal_pkg and the block under test.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
   import rcal_pkg::*;
   import tb_rcal_pkg::*;

   logic clock;
   logic reset;

   rcal_req_if req ();
   rcal_rsp_if rsp ();
   rcal_csr_if csr ();

   range_count_at_least_with_updates u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   logic signed [VALUE_W-1:0] elements [MAX_ELEMENTS_DEF];
   logic [LENGTH_W-1:0]       length_reg;
   logic [COUNT_W-1:0]        counts_due [$];
   request_type               pending [$];
   logic [LENGTH_W-1:0]       length_due [$];
   int  mismatches;
   int  send_idle_pct;
   int  stall_pct;
   int  hold_cycles;
   bit  hold_used;
   int  phase_num = -1;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sorted blocks only speed up the count, so a direct scan gives the same answer.
   function automatic logic [COUNT_W-1:0] count_at_least(request_type r);
      int unsigned len, right, cnt;
      len = (length_reg > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : length_reg;
      cnt = 0;
      if (len == 0 || r.operand < 0) return '0;
      right = r.operand;
      if (right > len - 1) right = len - 1;
      for (int unsigned i = r.position; i <= right; i++)
         if (elements[i] >= r.threshold) cnt++;
      if (cnt > len) cnt = len;
      if (cnt > 2047) cnt = 2047;
      return cnt[COUNT_W-1:0];
   endfunction

   function automatic int signed pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom();
         default: return $urandom_range(0, 40) - 20;
      endcase
   endfunction

   function automatic request_type make_item(bit mode, int unsigned pos, int signed op,
                                             int signed thr);
      request_type r;
      r.mode = mode;
      r.position = pos[POS_W-1:0];
      r.operand = op;
      r.threshold = thr;
      return r;
   endfunction

   function automatic request_type random_item(int unsigned len);
      int unsigned span;
      span = (len == 0) ? 1 : len;
      if ($urandom_range(0, 99) < 45)
         return make_item(MODE_WRITE, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                          : $urandom_range(0, span - 1), pick_value(), 0);
      if ($urandom_range(0, 9) == 0)
         return make_item(MODE_QUERY, $urandom_range(0, 1023), $urandom(), $urandom());
      return make_item(MODE_QUERY, $urandom_range(0, span - 1),
                       $urandom_range(0, span + 40) - 4, pick_value());
   endfunction

   // Driver: requests and length writes.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.mode <= 1'b0;
         req.position <= '0;
         req.operand <= '0;
         req.threshold <= '0;
         csr.valid <= 1'b0;
         csr.data <= '0;
         length_reg = LENGTH_RESET;
         for (int i = 0; i < MAX_ELEMENTS_DEF; i++) elements[i] = '0;
      end else begin
         if (csr.valid && csr.ready) begin
            length_reg = csr.data;
            csr.valid <= 1'b0;
         end else if (!csr.valid && length_due.size() != 0 && pending.size() == 0
                      && counts_due.size() == 0 && !req.valid) begin
            csr.valid <= 1'b1;
            csr.data <= length_due.pop_front();
         end
         if (req.valid && req.ready) begin
            if (req.mode == MODE_QUERY)
               counts_due.push_back(count_at_least({req.mode, req.position, req.operand,
                                                    req.threshold}));
            else if (req.position < ((length_reg > 1024) ? 1024 : length_reg))
               elements[req.position] = req.operand;
         end
         if ((!req.valid || req.ready) && pending.size() != 0
             && $urandom_range(0, 99) >= send_idle_pct) begin
            request_type r;
            r = pending.pop_front();
            req.valid <= 1'b1;
            {req.mode, req.position, req.operand, req.threshold} <= r;
         end else if (req.valid && req.ready) begin
            req.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold, started once in the third phase.
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
         hold_used <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (phase_num == 2 && !hold_used) begin
         hold_cycles <= 3000;
         hold_used <= 1'b1;
      end
   end

   // Monitor: result checks and receiver stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         mismatches = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (counts_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected count %0d", rsp.count);
            end else begin
               logic [COUNT_W-1:0] want;
               want = counts_due.pop_front();
               if (want !== rsp.count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("count mismatch: expected %0d actual %0d", want, rsp.count);
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic wait_drained();
      while (pending.size() != 0 || req.valid || counts_due.size() != 0
             || length_due.size() != 0 || csr.valid)
         @(posedge clock);
   endtask

   task automatic set_length(int unsigned len);
      wait_drained();
      repeat (400) @(posedge clock);
      length_due.push_back(len[LENGTH_W-1:0]);
      wait_drained();
   endtask

   initial begin
      int unsigned lens [6];
      int signed vals [4];
      lens = '{1024, 1, 37, 2047, 64, 0};
      vals = '{32'sh7fffffff, 32'sh80000000, 0, -1};
      send_idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 4; i++) pending.push_back(make_item(MODE_WRITE, i * 341, vals[i], 0));
      pending.push_back(make_item(MODE_WRITE, 1023, 32'sh7fffffff, 0));
      pending.push_back(make_item(MODE_WRITE, 1023, 32'sh7fffffff, 0));
      pending.push_back(make_item(MODE_WRITE, 5, 7, 0));
      pending.push_back(make_item(MODE_QUERY, 0, 1023, 32'sh80000000));
      pending.push_back(make_item(MODE_QUERY, 0, 32'sh7fffffff, 0));
      pending.push_back(make_item(MODE_QUERY, 1023, -5, 0));
      pending.push_back(make_item(MODE_QUERY, 900, 100, 0));
      pending.push_back(make_item(MODE_QUERY, 3, 70, 1));
      pending.push_back(make_item(MODE_QUERY, 32, 63, -1));
      pending.push_back(make_item(MODE_QUERY, 1023, 1023, 32'sh7fffffff));
      pending.push_back(make_item(MODE_QUERY, 0, 1023, 32'sh80000001));

      for (int ph = 0; ph < 6; ph++) begin
         set_length(lens[ph]);
         send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 69 : 0;
         stall_pct = (ph % 4 == 2) ? 69 : (ph % 4 == 3) ? 9 : 0;
         if (ph % 4 == 3) send_idle_pct = 9;
         phase_num = ph;
         for (int n = 0; n < 90; n++)
            pending.push_back(random_item((lens[ph] > 1024) ? 1024 : lens[ph]));
      end
      wait_drained();
      repeat (400) @(posedge clock);
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end
endmodule

`default_nettype wire
